@@ sv/bse_pkg.sv @@
package bse_pkg;

  localparam int VALUE_W         = 16;
  localparam int VALUE_RANGE_DEF = 65536;
  localparam int WORD_BITS_DEF   = 64;
  localparam int RECIP_SHIFT     = 32;

  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  typedef struct packed {
    logic clr_write;
    logic load_in;
    logic mul_en;
    logic scale_en;
    logic ins_read;
    logic ins_write;
    logic x_read;
    logic x_check;
    logic load_out;
  } bse_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic count_zero;
    logic word_zero;
  } bse_sts_t;

endpackage

@@ sv/bse_datapath.sv @@
module bse_datapath import bse_pkg::*; #(
  parameter int VALUE_RANGE = VALUE_RANGE_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  bse_cmd_t           cmd,
  output bse_sts_t           sts,
  input  logic [VALUE_W-1:0] value,
  output logic [VALUE_W-1:0] sorted_value,
  output logic               empty_res,
  output logic               last
);

  localparam int EFF_RANGE = (VALUE_RANGE < 2**VALUE_W) ? VALUE_RANGE : 2**VALUE_W;
  localparam int DEPTH     = (EFF_RANGE + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int CNT_W     = $clog2(DEPTH * WORD_BITS + 1);
  localparam int RECIP_W   = RECIP_SHIFT;
  localparam int PROD_W    = VALUE_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / WORD_BITS);

  logic [WORD_BITS-1:0] mem [DEPTH];

  logic [VALUE_W-1:0]   value_q;
  logic                 in_range;
  logic                 empty_sel;
  logic [PROD_W-1:0]    prod;
  logic [VALUE_W-1:0]   quot0;
  logic [VALUE_W-1:0]   qw;
  logic [ADDR_W-1:0]    widx;
  logic [BIT_W-1:0]     bidx;
  logic [WORD_BITS-1:0] rdata;
  logic [ADDR_W-1:0]    hint;
  logic [CNT_W-1:0]     count;
  logic [ADDR_W-1:0]    clr_addr;

  logic [VALUE_W-1:0]   rem;
  logic                 fix;
  logic [VALUE_W-1:0]   quot;
  logic [VALUE_W-1:0]   rbit;
  logic [ADDR_W-1:0]    widx_next;
  logic [BIT_W-1:0]     bidx_next;
  logic [WORD_BITS-1:0] ins_mask;
  logic                 is_new;
  logic                 ins_hit;
  logic [WORD_BITS-1:0] low1;
  logic [BIT_W-1:0]     low_idx;
  logic                 word_zero;
  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic [WORD_BITS-1:0] wdata;

  // quotient estimate is low by at most one
  assign rem       = value_q - qw;
  assign fix       = rem >= VALUE_W'(WORD_BITS);
  assign quot      = fix ? quot0 + VALUE_W'(1) : quot0;
  assign rbit      = fix ? rem - VALUE_W'(WORD_BITS) : rem;
  assign widx_next = ADDR_W'(quot);
  assign bidx_next = BIT_W'(rbit);

  assign ins_mask  = WORD_BITS'(1) << bidx;
  assign is_new    = (rdata & ins_mask) == '0;
  assign ins_hit   = cmd.ins_write && in_range && is_new;
  assign word_zero = rdata == '0;
  assign low1      = rdata & (~rdata + WORD_BITS'(1));

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low1[i]) begin
        low_idx = low_idx | BIT_W'(i);
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = hint;
    wdata = rdata & ~low1;
    if (cmd.clr_write) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else if (ins_hit) begin
      we    = 1'b1;
      waddr = widx;
      wdata = rdata | ins_mask;
    end else if (cmd.x_check && !word_zero) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.ins_read) begin
      rdata <= mem[widx_next];
    end else if (cmd.x_read) begin
      rdata <= mem[hint];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      value_q   <= value;
      in_range  <= 32'(value) < 32'(VALUE_RANGE);
      empty_sel <= count == '0;
    end
    if (cmd.mul_en) begin
      prod <= PROD_W'(value_q) * PROD_W'(RECIP);
    end
    if (cmd.scale_en) begin
      quot0 <= prod[PROD_W-1:RECIP_SHIFT];
      qw    <= VALUE_W'(prod[PROD_W-1:RECIP_SHIFT] * VALUE_W'(WORD_BITS));
    end
    if (cmd.ins_read) begin
      widx <= widx_next;
      bidx <= bidx_next;
    end else if (cmd.x_check) begin
      bidx <= low_idx;
    end
    if (cmd.load_out) begin
      if (empty_sel) begin
        sorted_value <= '0;
        empty_res    <= 1'b1;
        last         <= 1'b0;
      end else begin
        sorted_value <= VALUE_W'(VALUE_W'(hint) * VALUE_W'(WORD_BITS)) + VALUE_W'(bidx);
        empty_res    <= 1'b0;
        last         <= count == '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hint     <= '0;
      count    <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clr_write) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (ins_hit) begin
        count <= count + CNT_W'(1);
        if (count == '0 || widx < hint) begin
          hint <= widx;
        end
      end else if (cmd.x_check) begin
        if (word_zero) begin
          hint <= hint + ADDR_W'(1);
        end else begin
          count <= count - CNT_W'(1);
        end
      end
    end
  end

  assign sts.clr_done   = clr_addr == ADDR_W'(DEPTH - 1);
  assign sts.count_zero = count == '0;
  assign sts.word_zero  = word_zero;

endmodule

@@ sv/bse_ctrl.sv @@
module bse_ctrl import bse_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     mode,
  output logic     out_valid,
  input  logic     out_ready,
  output bse_cmd_t cmd,
  input  bse_sts_t sts
);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_MUL,
    S_SCALE,
    S_IRD,
    S_IWR,
    S_XRD,
    S_XCHK,
    S_XOUT
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = state == S_IDLE;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.clr_write = state == S_CLR;
    cmd.load_in   = accept;
    cmd.mul_en    = state == S_MUL;
    cmd.scale_en  = state == S_SCALE;
    cmd.ins_read  = state == S_IRD;
    cmd.ins_write = state == S_IWR;
    cmd.x_read    = state == S_XRD;
    cmd.x_check   = state == S_XCHK;
    cmd.load_out  = (state == S_XOUT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          if (sts.clr_done) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (mode == MODE_EXTRACT) begin
              state <= sts.count_zero ? S_XOUT : S_XRD;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL:   state <= S_SCALE;
        S_SCALE: state <= S_IRD;
        S_IRD:   state <= S_IWR;
        S_IWR:   state <= S_IDLE;
        S_XRD:   state <= S_XCHK;
        S_XCHK: begin
          state <= sts.word_zero ? S_XRD : S_XOUT;
        end
        S_XOUT: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

endmodule

@@ sv/bitmap_sort_engine.sv @@
// Channel | Handshake            | Payload
// input   | in_valid / in_ready   | mode, value
// output  | out_valid / out_ready | sorted_value, empty_res, last
//
// Insert: accept, reciprocal multiply, scale, word read, word write, in that order.
// Extract: accept, read and check each word the cursor visits, load output;
//   if empty, it skips to load output. The single-port bitmap memory sets the pace.
// Reset: clears control state, then sweeps the bitmap, one word a cycle,
//   all ceil(min(VALUE_RANGE, 65536) / WORD_BITS) words, with in_ready low.
// Stalls: a result waits in the output register; an extract holds in its last
//   step until that register frees up.
module bitmap_sort_engine import bse_pkg::*; #(
  parameter int VALUE_RANGE = VALUE_RANGE_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [VALUE_W-1:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VALUE_W-1:0] sorted_value,
  output logic               empty_res,
  output logic               last
);

  bse_cmd_t cmd;
  bse_sts_t sts;

  bse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bse_datapath #(
    .VALUE_RANGE (VALUE_RANGE),
    .WORD_BITS   (WORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .value        (value),
    .sorted_value (sorted_value),
    .empty_res    (empty_res),
    .last         (last)
  );

endmodule

@@ sv/bse_checker.sv @@
module bse_checker import bse_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [VALUE_W-1:0] sorted_value,
  input logic               empty_res,
  input logic               last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sorted_value) && $stable(empty_res)
      && $stable(last))
    else $error("output transaction changed while stalled");

  a_empty_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> sorted_value == '0 && !last)
    else $error("empty result carries a value or last");

  a_busy_after_accept: assert property (@(posedge clk)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input ready during bitmap clear");

endmodule

bind bitmap_sort_engine bse_checker u_bse_checker (.*);

@@ test/bitmap_sort_engine_tb.sv @@
`timescale 1ns / 1ps

module bitmap_sort_engine_tb;
  import bse_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 1700;
  localparam int SETTLE_CYCLES  = 20;
  localparam int LONG_HOLD      = 300;

  typedef struct packed {
    logic [VALUE_W-1:0] val;
    logic               is_empty;
    logic               is_last;
  } sort_result_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               mode;
  logic [VALUE_W-1:0] value;
  logic               out_valid;
  logic               out_ready;
  logic [VALUE_W-1:0] sorted_value;
  logic               empty_res;
  logic               last;

  sort_result_t pending_q[$];
  bit           held_values[int];
  int           fail_count  = 0;
  int           idle_cycles = 0;
  int           stall_hold  = 0;
  int           rx_wait     = 0;
  bit           tx_idle     = 1'b0;
  bit           rx_idle     = 1'b0;

  bitmap_sort_engine u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .empty_res    (empty_res),
    .last         (last)
  );

  always #5 clk = ~clk;

  function automatic logic [VALUE_W-1:0] rand_value(int lo, int hi);
    int v;
    v = $urandom_range(hi, lo);
    return v[VALUE_W-1:0];
  endfunction

  // Track the set of held values; an extract pops the smallest one.
  function automatic void predict_sort(logic m, logic [VALUE_W-1:0] v);
    sort_result_t r;
    int           lowest;
    if (m == MODE_INSERT) begin
      held_values[int'(v)] = 1'b1;
    end else begin
      r = '{val: '0, is_empty: 1'b1, is_last: 1'b0};
      if (held_values.first(lowest)) begin
        held_values.delete(lowest);
        r.val      = lowest[VALUE_W-1:0];
        r.is_empty = 1'b0;
        r.is_last  = (held_values.num() == 0);
      end
      pending_q.push_back(r);
    end
  endfunction

  task automatic send_item(input logic m, input logic [VALUE_W-1:0] v);
    int gap;
    gap = tx_idle ? $urandom_range(4, 0) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    mode     <= m;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    predict_sort(m, v);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_empty_extract();
    send_item(MODE_EXTRACT, '1);
    send_item(MODE_EXTRACT, '0);
    wait_drain();
  endtask

  task automatic test_value_extremes();
    logic [VALUE_W-1:0] vals[$] = '{16'hFFFF, 16'h0000, 16'h0000, 16'h8000, 16'd63,
                                    16'd64, 16'hAAAA, 16'h5555, 16'hFFC0};
    foreach (vals[i]) send_item(MODE_INSERT, vals[i]);
    repeat (vals.size()) send_item(MODE_EXTRACT, rand_value(0, 65535));
    wait_drain();
  endtask

  task automatic test_output_stall();
    tx_idle    = 1'b0;
    rx_idle    = 1'b0;
    stall_hold = LONG_HOLD;
    repeat (8) send_item(MODE_INSERT, rand_value(0, 2047));
    repeat (16) send_item(MODE_EXTRACT, rand_value(0, 65535));
    wait_drain();
  endtask

  task automatic test_pause_resume();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (10) send_item(MODE_INSERT, rand_value(4096, 8191));
    repeat (5) send_item(MODE_EXTRACT, rand_value(0, 65535));
    wait_drain();
    repeat (3) send_item(MODE_INSERT, rand_value(0, 4095));
    repeat (9) send_item(MODE_EXTRACT, rand_value(0, 65535));
    wait_drain();
  endtask

  task automatic test_random_batches();
    int sent;
    int n;
    int lo;
    int span;
    int pick;
    int extracts;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      tx_idle = ($urandom_range(3, 0) != 0);
      rx_idle = ($urandom_range(3, 0) != 0);
      pick    = $urandom_range(9, 0);
      if (pick < 4) begin
        span = 127;
        lo   = $urandom_range(65535 - span, 0);
      end else if (pick < 6) begin
        span = 63;
        lo   = $urandom_range(1023, 0) * 64;
      end else if (pick < 8) begin
        span = 65535;
        lo   = 0;
      end else begin
        span = 255;
        lo   = 65536 - 256;
      end
      n = $urandom_range(40, 1);
      repeat (n) send_item(MODE_INSERT, rand_value(lo, lo + span));
      extracts = ($urandom_range(3, 0) == 0) ? n / 2 : n + 1;
      repeat (extracts) send_item(MODE_EXTRACT, rand_value(0, 65535));
      sent += n + extracts;
      if ($urandom_range(4, 0) == 0) begin
        repeat (10) begin
          send_item($urandom_range(1, 0) ? MODE_EXTRACT : MODE_INSERT,
                    rand_value(lo, lo + (span > 255 ? 255 : span)));
        end
        sent += 10;
      end
    end
    wait_drain();
  endtask

  initial begin : rx_side
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) rx_wait = rx_idle ? $urandom_range(4, 0) : 0;
      @(negedge clk);
      if (stall_hold > 0) begin
        out_ready <= 1'b0;
        stall_hold--;
      end else if (rx_wait > 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    sort_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected transaction: sorted_value %0d empty_res %0d last %0d",
               sorted_value, empty_res, last);
        fail_count++;
      end else begin
        exp_r = pending_q.pop_front();
        if (sorted_value !== exp_r.val) begin
          $error("sorted_value: expected %0d, actual %0d", exp_r.val, sorted_value);
          fail_count++;
        end
        if (empty_res !== exp_r.is_empty) begin
          $error("empty_res: expected %0d, actual %0d", exp_r.is_empty, empty_res);
          fail_count++;
        end
        if (last !== exp_r.is_last) begin
          $error("last: expected %0d, actual %0d", exp_r.is_last, last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[bitmap_sort_engine] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    mode     = MODE_INSERT;
    value    = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_empty_extract();
    test_value_extremes();
    test_output_stall();
    test_pause_resume();
    test_random_batches();
    if (fail_count == 0) begin
      $display("[bitmap_sort_engine] OK");
    end else begin
      $display("[bitmap_sort_engine] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/bse_pkg.sv
sv/bse_datapath.sv
sv/bse_ctrl.sv
sv/bitmap_sort_engine.sv
sv/bse_checker.sv
test/bitmap_sort_engine_tb.sv
